FILE: rtl/biq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_pkg
// shared types, widths and register codes of the multichannel biquad filter
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int COEF_W           = 32;
  localparam int PROD_W           = SAMPLE_W + COEF_W;
  localparam int SUM_W            = PROD_W + 3;
  localparam int FRAC_BITS        = 28;
  localparam int RES_W            = SUM_W - FRAC_BITS;
  localparam int APB_ADDR_W       = 5;
  localparam int APB_DATA_W       = 32;
  localparam int DEFAULT_CHANNELS = 2;

  localparam logic [COEF_W-1:0] B0_RESET = COEF_W'(32'h1000_0000);
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'd1 << (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coefs_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } delay_t;

endpackage

FILE: rtl/biq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_regs
// apb coefficient registers, shared by all channels
// ----------------------------------------------------------------------------
module biq_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [biq_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [biq_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [biq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output biq_pkg::coefs_t                  coefs
);
  import biq_pkg::*;

  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_B0:  coefs.b0 <= pwdata;
        REG_B1:  coefs.b1 <= pwdata;
        REG_B2:  coefs.b2 <= pwdata;
        REG_A1:  coefs.a1 <= pwdata;
        REG_A2:  coefs.a2 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_B0:  prdata = coefs.b0;
      REG_B1:  prdata = coefs.b1;
      REG_B2:  prdata = coefs.b2;
      REG_A1:  prdata = coefs.a1;
      REG_A2:  prdata = coefs.a2;
      default: prdata = '0;
    endcase
  end

endmodule

FILE: rtl/biq_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_state_mem
// per-channel delay line memory, registered read, entries read as zero
// until first written after reset
// ----------------------------------------------------------------------------
module biq_state_mem #(
  parameter int  CHANNELS = biq_pkg::DEFAULT_CHANNELS,
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output biq_pkg::delay_t     rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  biq_pkg::delay_t     wr_data
);
  import biq_pkg::*;

  delay_t              mem [CHANNELS];
  logic [CHANNELS-1:0] ent_valid;
  delay_t              rd_word;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= ent_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: rtl/biq_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_mac
// five products, two partial sums, then rounding and saturation to 24 bits
// ----------------------------------------------------------------------------
module biq_mac (
  input  logic              clk,
  input  logic              en,
  input  biq_pkg::sample_t  x,
  input  biq_pkg::delay_t   dly,
  input  biq_pkg::coefs_t   coefs,
  output biq_pkg::sample_t  y
);
  import biq_pkg::*;

  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
  logic signed [SUM_W-1:0]  ff, fb;
  logic signed [SUM_W-1:0]  acc;
  logic signed [RES_W-1:0]  r;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= $signed(coefs.b0) * $signed(x);
      p1 <= $signed(coefs.b1) * $signed(dly.x1);
      p2 <= $signed(coefs.b2) * $signed(dly.x2);
      p3 <= $signed(coefs.a1) * $signed(dly.y1);
      p4 <= $signed(coefs.a2) * $signed(dly.y2);
      ff <= {{(SUM_W-PROD_W){p0[PROD_W-1]}}, p0}
          + {{(SUM_W-PROD_W){p1[PROD_W-1]}}, p1}
          + {{(SUM_W-PROD_W){p2[PROD_W-1]}}, p2};
      fb <= {{(SUM_W-PROD_W){p3[PROD_W-1]}}, p3}
          + {{(SUM_W-PROD_W){p4[PROD_W-1]}}, p4};
    end
  end

  assign acc = ff - fb + $signed(ROUND_BIAS);
  assign r   = acc[SUM_W-1:FRAC_BITS];
  assign ovf = !((&r[RES_W-1:SAMPLE_W-1]) || !(|r[RES_W-1:SAMPLE_W-1]));

  always_comb begin
    if (!ovf) begin
      y = r[SAMPLE_W-1:0];
    end else if (r[RES_W-1]) begin
      y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

FILE: rtl/multichannel_biquad_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_unit
// direct form i biquad, shared coefficients, per-channel delay state in memory
// ----------------------------------------------------------------------------
// an input transaction passes s1, s2 and s3, then its result is registered on the
//   master side; all stages hold while m_tvalid waits on m_tready. Other channels'
//   items are taken while older ones are in flight; an item stalls while its channel
//   is in s1-s3 (delay state read at accept, written back as it leaves s3)
// reset: b0 = 1.0, other gains 0; delay state reads as zero per channel until
//   first written, no clearing pass
module multichannel_biquad_filter_unit #(
  parameter int CHANNELS = biq_pkg::DEFAULT_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [biq_pkg::SAMPLE_W-1:0]    s_tdata,   // sample_in
  input  logic [0:0]                      s_tuser,   // channel_in
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [biq_pkg::SAMPLE_W-1:0]    m_tdata,   // sample_out
  output logic [0:0]                      m_tuser,   // channel_out
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [biq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [biq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [biq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import biq_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  coefs_t           coefs;
  delay_t           rd_dly;
  delay_t           wr_dly;
  sample_t          y;

  logic             adv;
  logic             hazard;
  logic             accept;
  logic [IDX_W-1:0] in_idx;

  logic             s1_valid, s2_valid, s3_valid;
  sample_t          s1_x, s2_x, s3_x;
  sample_t          s2_x1, s3_x1;
  sample_t          s2_y1, s3_y1;
  logic [IDX_W-1:0] s1_idx, s2_idx, s3_idx;
  logic             s1_chan, s2_chan, s3_chan;

  biq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  assign in_idx = (CHANNELS > 1) ? IDX_W'(s_tuser[0]) : '0;

  // stall while an older transaction of the same channel has not written back
  assign hazard = (s1_valid && (s1_idx == in_idx))
               || (s2_valid && (s2_idx == in_idx))
               || (s3_valid && (s3_idx == in_idx));
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !hazard;
  assign accept   = s_tvalid && s_tready;

  assign wr_dly.x1 = s3_x;
  assign wr_dly.x2 = s3_x1;
  assign wr_dly.y1 = y;
  assign wr_dly.y2 = s3_y1;

  biq_state_mem #(
    .CHANNELS (CHANNELS)
  ) u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (rd_dly),
    .wr_en   (adv && s3_valid),
    .wr_addr (s3_idx),
    .wr_data (wr_dly)
  );

  biq_mac u_mac (
    .clk   (clk),
    .en    (adv),
    .x     (s1_x),
    .dly   (rd_dly),
    .coefs (coefs),
    .y     (y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x    <= s_tdata;
      s1_idx  <= in_idx;
      s1_chan <= s_tuser[0];
      s2_x    <= s1_x;
      s2_x1   <= rd_dly.x1;
      s2_y1   <= rd_dly.y1;
      s2_idx  <= s1_idx;
      s2_chan <= s1_chan;
      s3_x    <= s2_x;
      s3_x1   <= s2_x1;
      s3_y1   <= s2_y1;
      s3_idx  <= s2_idx;
      s3_chan <= s2_chan;
      m_tdata <= y;
      m_tuser <= s3_chan;
    end
  end

endmodule
